[rtl/zlhs_pkg.sv]
package zlhs_pkg;

  localparam int unsigned HdrBytes = 30;

  localparam logic [31:0] LOCAL_SIG = 32'h0403_4b50;
  localparam logic [31:0] DESC_SIG  = 32'h0807_4b50;
  localparam int unsigned DescFlagBit = 3;
  localparam logic [11:0] YEAR_BASE = 12'd1980;
  localparam logic [6:0]  CHAR_SUBST = 7'h3f;

  // result kinds, carried on the output tuser
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_NAME   = 2'd1;
  localparam logic [1:0] KIND_DESC   = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] comp_len;
    logic [31:0] raw_len;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [6:0]  name_char;
  } result_t;

endpackage

[rtl/zlhs_parser.sv]
module zlhs_parser
  import zlhs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_start_i,
  output logic          res_valid_o,
  output result_t       res_o,
  input  logic          res_ready_i
);

  localparam logic [2:0] PH_HDR   = 3'd0;
  localparam logic [2:0] PH_NAME  = 3'd1;
  localparam logic [2:0] PH_EXTRA = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_DESC  = 3'd4;
  localparam logic [2:0] PH_DREAD = 3'd5;
  localparam logic [2:0] PH_NEXT  = 3'd6;

  // input register
  logic       item_valid_q;
  logic [7:0] byte_q;
  logic       start_q;
  logic       fire;

  assign fire       = item_valid_q && res_ready_i;
  assign in_ready_o = !item_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= in_byte_i;
      start_q <= in_start_i;
    end
  end

  // parser state
  logic [2:0]  phase_q, phase_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] window_q, window_d;
  logic [3:0]  dcnt_q, dcnt_d;
  logic [63:0] dfields_q, dfields_d;
  logic [7:0]  hdr_q [HdrBytes];
  logic [7:0]  hdr_d [HdrBytes];
  logic [7:0]  hdr_view [HdrBytes];

  logic [2:0]  phase_e;
  logic [4:0]  cnt_e;
  logic [31:0] win;
  logic [15:0] name_len, extra_len, dos_time, dos_date, flags;
  logic [31:0] csize, usize;
  logic [2:0]  ae_phase, an_phase;
  logic [31:0] ae_skip, an_skip;
  logic [3:0]  dofs;
  logic        res_valid;
  result_t     res;

  always_comb begin
    phase_e = start_q ? PH_HDR : phase_q;
    cnt_e   = start_q ? 5'd0 : cnt_q;

    // header bytes with the current byte in its slot
    for (int k = 0; k < HdrBytes; k++) begin
      hdr_view[k] = (cnt_e == 5'(k)) ? byte_q : hdr_q[k];
    end

    flags     = {hdr_view[7], hdr_view[6]};
    dos_time  = {hdr_view[11], hdr_view[10]};
    dos_date  = {hdr_view[13], hdr_view[12]};
    csize     = {hdr_view[21], hdr_view[20], hdr_view[19], hdr_view[18]};
    usize     = {hdr_view[25], hdr_view[24], hdr_view[23], hdr_view[22]};
    name_len  = {hdr_view[27], hdr_view[26]};
    extra_len = {hdr_view[29], hdr_view[28]};

    // where the entry goes once name, then extra field, are done
    if (csize != 32'd0) begin
      ae_phase = PH_DATA;
    end else if (flags[DescFlagBit]) begin
      ae_phase = PH_DESC;
    end else begin
      ae_phase = PH_NEXT;
    end
    ae_skip  = csize;
    an_phase = (extra_len != 16'd0) ? PH_EXTRA : ae_phase;
    an_skip  = (extra_len != 16'd0) ? {16'd0, extra_len} : ae_skip;

    win  = {byte_q, window_q[31:8]};
    dofs = dcnt_q - 4'd4;

    phase_d   = phase_e;
    cnt_d     = cnt_e;
    skip_d    = skip_q;
    window_d  = 32'd0;
    dcnt_d    = dcnt_q;
    dfields_d = dfields_q;
    hdr_d     = hdr_q;
    res_valid = 1'b0;
    res       = '0;

    unique case (phase_e)
      PH_NAME: begin
        res_valid     = 1'b1;
        res.kind      = KIND_NAME;
        res.name_char = (byte_q >= 8'h20 && byte_q <= 8'h7e) ? byte_q[6:0] : CHAR_SUBST;
        skip_d        = skip_q - 32'd1;
        if (skip_q == 32'd1) begin
          phase_d = an_phase;
          skip_d  = an_skip;
        end
      end
      PH_EXTRA: begin
        skip_d = skip_q - 32'd1;
        if (skip_q == 32'd1) begin
          phase_d = ae_phase;
          skip_d  = ae_skip;
        end
      end
      PH_DATA: begin
        skip_d = skip_q - 32'd1;
        if (skip_q == 32'd1) begin
          phase_d   = PH_HDR;
          cnt_d     = 5'd0;
          res_valid = 1'b1;
          res.kind  = KIND_END;
        end
      end
      PH_DESC, PH_NEXT: begin
        window_d = win;
        if (win == LOCAL_SIG) begin
          // signature bytes open the next header
          hdr_d[0]  = LOCAL_SIG[7:0];
          hdr_d[1]  = LOCAL_SIG[15:8];
          hdr_d[2]  = LOCAL_SIG[23:16];
          hdr_d[3]  = LOCAL_SIG[31:24];
          cnt_d     = 5'd4;
          phase_d   = PH_HDR;
          res_valid = 1'b1;
          res.kind  = KIND_END;
        end else if (phase_e == PH_DESC && win == DESC_SIG) begin
          phase_d = PH_DREAD;
          dcnt_d  = 4'd0;
        end
      end
      PH_DREAD: begin
        if (dcnt_q >= 4'd4) begin
          dfields_d[8*dofs[2:0] +: 8] = byte_q;
        end
        if (dcnt_q >= 4'd11) begin
          res_valid    = 1'b1;
          res.kind     = KIND_DESC;
          res.comp_len = dfields_q[31:0];
          res.raw_len  = {byte_q, dfields_q[55:32]};
          phase_d      = PH_NEXT;
        end else begin
          dcnt_d = dcnt_q + 4'd1;
        end
      end
      default: begin
        hdr_d   = hdr_view;
        phase_d = PH_HDR;
        if (cnt_e < 5'(HdrBytes - 1)) begin
          cnt_d = cnt_e + 5'd1;
        end else begin
          cnt_d = 5'd0;
          if ({hdr_view[3], hdr_view[2], hdr_view[1], hdr_view[0]} == LOCAL_SIG) begin
            res_valid    = 1'b1;
            res.kind     = KIND_HEADER;
            res.comp_len = csize;
            res.raw_len  = usize;
            res.year     = {5'd0, dos_date[15:9]} + YEAR_BASE;
            res.month    = dos_date[8:5];
            res.day      = dos_date[4:0];
            res.hour     = dos_time[15:11];
            res.minute   = dos_time[10:5];
            res.second   = {dos_time[4:0], 1'b0};
            if (name_len != 16'd0) begin
              phase_d = PH_NAME;
              skip_d  = {16'd0, name_len};
            end else begin
              phase_d = an_phase;
              skip_d  = an_skip;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR;
      cnt_q    <= 5'd0;
      skip_q   <= 32'd0;
      window_q <= 32'd0;
      dcnt_q   <= 4'd0;
    end else if (fire) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      skip_q   <= skip_d;
      window_q <= window_d;
      dcnt_q   <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      hdr_q     <= hdr_d;
      dfields_q <= dfields_d;
    end
  end

  assign res_valid_o = fire && res_valid;
  assign res_o       = res;

endmodule

[rtl/zlhs_out_fifo.sv]
module zlhs_out_fifo
  import zlhs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    ready_o,
  output logic    valid_o,
  output result_t data_o,
  input  logic    pop_ready_i
);

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign push    = push_i && ready_o;
  assign pop     = valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/zip_local_header_scanner_core.sv]
// Archive local header scanner.
// Slave stream: one archive byte per transfer in tdata; tuser set on the
// first byte of a new archive restarts the parser before that byte is used.
// Master stream: at most one result per input byte, in byte order; tuser
// carries the kind (entry header, name character, descriptor sizes, entry
// end), tdata the sizes, decoded DOS date/time and name character, with
// fields not used by a kind driven to zero.
// Throughput: one byte per cycle while the output buffer has space. Each
// byte sits in an input register, is parsed from there and its result is
// written into a two-entry output buffer, from which the master side offers
// it; while the buffer is full the byte is held in the input register.
// When the receiver stalls the output buffer fills; after two results are
// held the parser stops and tready drops on the slave side. Bytes that make
// no result still wait for buffer space.
// Reset: asynchronous, active low; the parser waits for a local header and
// both buffers are emptied.
module zip_local_header_scanner_core
  import zlhs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]   s_axis_tuser,   // [0] start_of_archive
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] comp_len, [63:32] raw_len, [75:64] year,
  // [79:76] month, [84:80] day, [89:85] hour, [95:90] minute,
  // [101:96] second, [108:102] name_char, [111:109] zero
  output logic [111:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // [1:0] kind
);

  logic    res_valid;
  logic    fifo_ready;
  result_t res;
  result_t out_res;

  zlhs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser[0]),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (fifo_ready)
  );

  zlhs_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (fifo_ready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_res),
    .pop_ready_i (m_axis_tready)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {3'd0, out_res.name_char, out_res.second, out_res.minute,
                         out_res.hour, out_res.day, out_res.month, out_res.year,
                         out_res.raw_len, out_res.comp_len};

endmodule

[tb/zlhs_result_checker.sv]
`timescale 1ns / 100ps

module zlhs_result_checker
  import zlhs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [7:0]   s_tdata_i,
  input  logic [0:0]   s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [111:0] m_tdata_i,
  input  logic [1:0]   m_tuser_i,
  output int           err_count_o,
  output int           in_flight_o
);

  typedef enum logic [2:0] {
    ST_HDR, ST_NAME, ST_EXTRA, ST_DATA, ST_DESC, ST_DREAD, ST_NEXT
  } scan_state_e;

  scan_state_e scan_st;
  logic [4:0]  hdr_cnt;
  logic [7:0]  hdr_bytes [HdrBytes];
  logic [31:0] skip_left;
  logic [31:0] sig_win;
  logic [3:0]  desc_cnt;
  logic [63:0] desc_sizes;

  result_t parsed_q [$];
  result_t new_rec;
  result_t want;

  function automatic logic [15:0] hdr16(int unsigned i);
    return {hdr_bytes[i+1], hdr_bytes[i]};
  endfunction

  function automatic logic [31:0] hdr32(int unsigned i);
    return {hdr16(i + 2), hdr16(i)};
  endfunction

  function automatic void clear_hdr();
    foreach (hdr_bytes[k]) hdr_bytes[k] = 8'h00;
    hdr_cnt = 5'd0;
  endfunction

  function automatic void clear_scan();
    clear_hdr();
    scan_st    = ST_HDR;
    skip_left  = 32'd0;
    sig_win    = 32'd0;
    desc_cnt   = 4'd0;
    desc_sizes = 64'd0;
  endfunction

  function automatic void start_hunt();
    sig_win = 32'd0;
    scan_st = hdr_bytes[6][DescFlagBit] ? ST_DESC : ST_NEXT;
  endfunction

  function automatic void after_extra();
    if (hdr32(18) != 32'd0) begin
      skip_left = hdr32(18);
      scan_st   = ST_DATA;
    end else begin
      start_hunt();
    end
  endfunction

  function automatic void after_name();
    if (hdr16(28) != 16'd0) begin
      skip_left = {16'd0, hdr16(28)};
      scan_st   = ST_EXTRA;
    end else begin
      after_extra();
    end
  endfunction

  // next header found by the hunt: its signature is already taken
  function automatic void found_header();
    clear_hdr();
    {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]} = LOCAL_SIG;
    hdr_cnt = 5'd4;
    scan_st = ST_HDR;
  endfunction

  // advances the parse by one archive byte; returns 1 when a record results
  function automatic bit parse_byte(input logic [7:0] b, input logic restart,
                                    output result_t rec);
    int unsigned pos;
    int unsigned idx;
    logic [15:0] tm;
    logic [15:0] dt;
    rec = '0;
    if (restart) clear_scan();
    case (scan_st)
      ST_NAME: begin
        rec.kind      = KIND_NAME;
        rec.name_char = (b >= 8'h20 && b <= 8'h7e) ? b[6:0] : CHAR_SUBST;
        skip_left--;
        if (skip_left == 32'd0) after_name();
        return 1'b1;
      end
      ST_EXTRA: begin
        skip_left--;
        if (skip_left == 32'd0) after_extra();
        return 1'b0;
      end
      ST_DATA: begin
        skip_left--;
        if (skip_left == 32'd0) begin
          clear_hdr();
          scan_st  = ST_HDR;
          rec.kind = KIND_END;
          return 1'b1;
        end
        return 1'b0;
      end
      ST_DESC, ST_NEXT: begin
        sig_win = {b, sig_win[31:8]};
        if (sig_win == LOCAL_SIG) begin
          found_header();
          rec.kind = KIND_END;
          return 1'b1;
        end
        if (scan_st == ST_DESC && sig_win == DESC_SIG) begin
          scan_st    = ST_DREAD;
          desc_cnt   = 4'd0;
          desc_sizes = 64'd0;
        end
        return 1'b0;
      end
      ST_DREAD: begin
        idx = 32'(desc_cnt);
        // crc in bytes 0..3 is dropped, sizes follow
        if (idx >= 4 && idx < 12) desc_sizes[(idx - 4) * 8 +: 8] = b;
        if (idx >= 11) begin
          rec.kind     = KIND_DESC;
          rec.comp_len = desc_sizes[31:0];
          rec.raw_len  = desc_sizes[63:32];
          sig_win = 32'd0;
          scan_st = ST_NEXT;
          return 1'b1;
        end
        desc_cnt = 4'(idx + 1);
        return 1'b0;
      end
      default: begin
        pos = 32'(hdr_cnt);
        if (pos >= HdrBytes) pos = 0;
        scan_st = ST_HDR;
        hdr_bytes[pos] = b;
        pos++;
        if (pos < HdrBytes) begin
          hdr_cnt = 5'(pos);
          return 1'b0;
        end
        hdr_cnt = 5'd0;
        if (hdr32(0) != LOCAL_SIG) begin
          clear_hdr();
          return 1'b0;
        end
        tm = hdr16(10);
        dt = hdr16(12);
        rec.kind     = KIND_HEADER;
        rec.comp_len = hdr32(18);
        rec.raw_len  = hdr32(22);
        rec.year   = YEAR_BASE + {5'd0, dt[15:9]};
        rec.month  = dt[8:5];
        rec.day    = dt[4:0];
        rec.hour   = tm[15:11];
        rec.minute = tm[10:5];
        rec.second = {tm[4:0], 1'b0};
        if (hdr16(26) != 16'd0) begin
          skip_left = {16'd0, hdr16(26)};
          scan_st   = ST_NAME;
        end else begin
          after_name();
        end
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void check_field(string label, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", label, exp_v, got_v);
      err_count_o++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_scan();
      parsed_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        if (parse_byte(s_tdata_i, s_tuser_i[0], new_rec)) parsed_q.push_back(new_rec);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (parsed_q.size() == 0) begin
          $error("result transfer with nothing expected, kind %0d", m_tuser_i);
          err_count_o++;
        end else begin
          want = parsed_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(m_tuser_i));
          check_field("comp_len", want.comp_len, m_tdata_i[31:0]);
          check_field("raw_len", want.raw_len, m_tdata_i[63:32]);
          check_field("year", 32'(want.year), 32'(m_tdata_i[75:64]));
          check_field("month", 32'(want.month), 32'(m_tdata_i[79:76]));
          check_field("day", 32'(want.day), 32'(m_tdata_i[84:80]));
          check_field("hour", 32'(want.hour), 32'(m_tdata_i[89:85]));
          check_field("minute", 32'(want.minute), 32'(m_tdata_i[95:90]));
          check_field("second", 32'(want.second), 32'(m_tdata_i[101:96]));
          check_field("name_char", 32'(want.name_char), 32'(m_tdata_i[108:102]));
          check_field("tdata pad", 32'd0, 32'(m_tdata_i[111:109]));
        end
      end
    end
    in_flight_o = parsed_q.size();
  end

endmodule

[tb/zip_local_header_scanner_core_tb.sv]
`timescale 1ns / 100ps

module zip_local_header_scanner_core_tb;
  import zlhs_pkg::*;

  localparam int IdleLimit  = 1000;
  localparam int HoldCycles = 120;
  localparam int RandBytes  = 180;

  logic         clk_i;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = 8'h00;
  logic [0:0]   s_axis_tuser  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  int err_count;
  int in_flight;
  int idle_cycles;
  int sent_bytes;
  bit quiet_tx;
  bit hold_req;
  bit hold_done;

  // archive bytes waiting to go out: {start_of_archive, data_byte}
  logic [8:0] byte_q [$];
  bit         soa_pending;

  zip_local_header_scanner_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  zlhs_result_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .err_count_o(err_count),
    .in_flight_o(in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_b(logic [7:0] b);
    byte_q.push_back({soa_pending, b});
    soa_pending = 1'b0;
  endfunction

  function automatic void push16(logic [15:0] v);
    push_b(v[7:0]);
    push_b(v[15:8]);
  endfunction

  function automatic void push32(logic [31:0] v);
    push16(v[15:0]);
    push16(v[31:16]);
  endfunction

  function automatic void push_noise(int n);
    repeat (n) push_b(8'($urandom));
  endfunction

  function automatic void push_header(logic [31:0] sig, logic [15:0] flags,
                                      logic [15:0] tm, logic [15:0] dt,
                                      logic [31:0] csize, logic [31:0] usize,
                                      logic [15:0] nlen, logic [15:0] xlen);
    push32(sig);
    push16(16'($urandom));          // version needed
    push16(flags);
    push16(16'($urandom));          // method
    push16(tm);
    push16(dt);
    push32($urandom);               // crc
    push32(csize);
    push32(usize);
    push16(nlen);
    push16(xlen);
  endfunction

  // header plus random name, extra and data; csize is kept small by callers
  function automatic void push_entry(logic [15:0] flags, logic [15:0] tm, logic [15:0] dt,
                                     logic [31:0] csize, logic [31:0] usize,
                                     logic [15:0] nlen, logic [15:0] xlen);
    push_header(LOCAL_SIG, flags, tm, dt, csize, usize, nlen, xlen);
    push_noise(nlen + xlen + csize);
  endfunction

  function automatic void push_desc(logic [31:0] csize, logic [31:0] usize);
    push32(DESC_SIG);
    push32($urandom);
    push32(csize);
    push32(usize);
  endfunction

  task automatic send_byte(input logic [8:0] item);
    int gap;
    gap = quiet_tx ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item[7:0];
    s_axis_tuser  <= item[8];
    do @(posedge clk_i); while (!s_axis_tready);
    sent_bytes++;
  endtask

  task automatic play();
    while (byte_q.size() > 0) send_byte(byte_q.pop_front());
  endtask

  // called on the step of the last transfer; waits out every pending result
  task automatic park_and_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (in_flight == 0);
  endtask

  // receiver side: random back-pressure plus one long hold-off on request
  initial begin : rx_side
    int stall;
    int run;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        run = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        repeat (run) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : tx_side
    int          sel;
    int unsigned dlen;
    int unsigned stop_at;
    int unsigned half_at;
    bit          paused;
    logic [15:0] flags;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // maximal date and time, name bytes across the printable boundaries
    soa_pending = 1'b1;
    push_header(LOCAL_SIG, 16'h0000, 16'hffff, 16'hffff, 32'd3, 32'hffff_ffff, 16'd8, 16'd2);
    push_b(8'h61); push_b(8'h00); push_b(8'h7e); push_b(8'h7f);
    push_b(8'h20); push_b(8'h1f); push_b(8'hff); push_b(8'h80);
    push_noise(2 + 3);
    // empty entry, zero date, descriptor with extreme sizes after some noise
    push_entry(16'h0008, 16'h0000, 16'h0000, 32'd0, 32'd0, 16'd0, 16'd0);
    push_noise(2);
    push_desc(32'hffff_ffff, 32'h0000_0000);
    push_noise(1);
    // no descriptor flag: a descriptor signature is only hunted over
    push_entry(16'hfff7, 16'($urandom), 16'($urandom), 32'd0, $urandom, 16'd1, 16'd0);
    push_desc(32'd1, 32'd2);
    // partial signature split around the hunt start must not match;
    // then the next header lands while a descriptor is awaited
    push_header(LOCAL_SIG, 16'h0008, 16'($urandom), 16'($urandom), 32'd0, $urandom,
                16'd0, 16'd2);
    push_b(8'h50); push_b(8'h4b); push_b(8'h03); push_b(8'h04);
    push_entry(16'h0000, 16'($urandom), 16'($urandom), 32'd2, $urandom, 16'd1, 16'd0);
    // block with a broken signature is dropped whole
    push_header(LOCAL_SIG ^ 32'h0000_0100, 16'h0000, 16'h1234, 16'h5678, 32'd1, 32'd1,
                16'd1, 16'd0);
    push_entry(16'h0000, 16'($urandom), 16'($urandom), 32'd1, $urandom, 16'd0, 16'd1);
    // huge data size cut short by a restart
    push_header(LOCAL_SIG, 16'h0000, 16'($urandom), 16'($urandom), 32'hffff_ffff, $urandom,
                16'd0, 16'd0);
    push_noise(3);
    soa_pending = 1'b1;
    push_entry(16'h0000, 16'($urandom), 16'($urandom), 32'd1, $urandom, 16'd2, 16'd0);
    play();
    park_and_drain();

    // random archives; the receiver holds off once near the start
    hold_req = 1'b1;
    half_at  = sent_bytes + RandBytes / 2;
    stop_at  = sent_bytes + RandBytes;
    paused   = 1'b0;
    while (sent_bytes < stop_at) begin
      quiet_tx = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 78) begin
        flags = 16'($urandom);
        dlen  = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
        push_entry(flags, 16'($urandom), 16'($urandom), dlen, $urandom,
                   16'(($urandom_range(0, 9) == 0) ? $urandom_range(7, 14)
                                                  : $urandom_range(0, 4)),
                   16'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3)));
        if (dlen == 0) begin
          push_noise($urandom_range(0, 2));
          if (flags[DescFlagBit] && $urandom_range(0, 3) != 0) push_desc($urandom, $urandom);
          push_noise($urandom_range(0, 2));
        end
      end else if (sel < 86) begin
        push_header(LOCAL_SIG ^ (32'd1 << $urandom_range(0, 31)), 16'($urandom),
                    16'($urandom), 16'($urandom), $urandom_range(1, 4), $urandom,
                    16'($urandom_range(0, 3)), 16'd0);
      end else if (sel < 93) begin
        // truncated entry with arbitrary lengths, recovered by a restart
        push_header(LOCAL_SIG, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                    $urandom, 16'($urandom), 16'($urandom));
        push_noise($urandom_range(0, 5));
        soa_pending = 1'b1;
      end else if (sel < 97) begin
        push_noise($urandom_range(1, 12));
        soa_pending = 1'b1;
      end else begin
        soa_pending = 1'b1;
      end
      play();
      if (!paused && sent_bytes >= half_at) begin
        paused = 1'b1;
        park_and_drain();
      end
    end
    park_and_drain();
    repeat (8) @(posedge clk_i);

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
